// File: hw/rtl/vsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_pkg
// types, codes and constants shared by the voice steal allocator
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int DEF_VOICE_SLOTS = 32;
    localparam logic [5:0] MAX_VOICES_RST = 6'd32;

    typedef enum logic [1:0] {
        OP_PLAY     = 2'd0,
        OP_UPDATE   = 2'd1,
        OP_STOP     = 2'd2,
        OP_LISTENER = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NOSLOT  = 2'd3
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic [31:0]        handle;
        logic [7:0]         priority_req;
        logic [15:0]        volume;
        logic               spatialized;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [22:0]        near_distance;
        logic [22:0]        far_distance;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] new_handle;
        logic        evicted;
        logic [31:0] evicted_handle;
        logic [5:0]  active_count;
    } t_out;

    typedef struct packed {
        logic [31:0] handle;
        logic [7:0]  prio;
        logic [15:0] volume;
        logic        spatial;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [22:0] near_d;
        logic [22:0] far_d;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE, S_CAP, S_INSC, S_SCAN, S_LOAD, S_SCORE,
        S_DECIDE, S_ALLOC, S_FSCAN, S_FCHK, S_LIS, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_IDLE, A_MUL, A_CMP, A_SQRT, A_DIV, A_DONE
    } t_aud_state;

    typedef struct packed {
        logic    load_req;
        logic    idx_inc;
        logic    aud_start;
        logic    aud_sel_ram;
        logic    save_ia;
        logic    consider;
        logic    free_best;
        logic    free_idx;
        logic    alloc;
        logic    wr_params;
        logic    set_listener;
        logic    st_we;
        t_status st_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic cap_hit;
        logic aud_done;
        logic idx_end;
        logic idx_valid;
        logic match;
        logic handle_zero;
        logic refuse;
        logic has_free;
        logic out_free;
    } t_sts;

endpackage

// File: hw/rtl/vsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module vsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/vsa_aud.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_aud
// audibility unit: squared distance, bit serial square root and divide
// ----------------------------------------------------------------------------
module vsa_aud
    import vsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_vol,
    input  logic        i_spatial,
    input  logic [23:0] i_x,
    input  logic [23:0] i_y,
    input  logic [23:0] i_z,
    input  logic [23:0] i_lx,
    input  logic [23:0] i_ly,
    input  logic [23:0] i_lz,
    input  logic [22:0] i_near,
    input  logic [22:0] i_far,
    output logic        o_done,
    output logic [15:0] o_aud
);
    t_aud_state r_state, n_state;

    logic [2:0]  r_step;
    logic [5:0]  r_cnt;
    logic [15:0] r_vol;
    logic [22:0] r_near, r_far;
    logic [24:0] r_ax, r_ay, r_az;
    logic [49:0] r_prod;
    logic [50:0] r_dsq;
    logic [45:0] r_far2, r_near2;
    logic [38:0] r_vn;
    logic [50:0] r_rem, r_res, r_bit;
    logic [38:0] r_q;
    logic [25:0] r_r, r_dv;
    logic [15:0] r_aud;

    logic signed [24:0] dx, dy, dz;
    logic [24:0] ma, mb;
    logic [51:0] sq_sum;
    logic        sq_ge;
    logic [50:0] n_res, n_rem;
    logic [26:0] dv_t;
    logic        dv_ge;
    logic [25:0] n_r;
    logic [38:0] n_q;
    logic        far_out, near_in;

    assign dx = 25'(signed'(i_x)) - 25'(signed'(i_lx));
    assign dy = 25'(signed'(i_y)) - 25'(signed'(i_ly));
    assign dz = 25'(signed'(i_z)) - 25'(signed'(i_lz));

    always_comb begin
        case (r_step)
            3'd0: begin ma = r_ax; mb = r_ax; end
            3'd1: begin ma = r_ay; mb = r_ay; end
            3'd2: begin ma = r_az; mb = r_az; end
            3'd3: begin ma = 25'(r_far); mb = 25'(r_far); end
            3'd4: begin ma = 25'(r_near); mb = 25'(r_near); end
            3'd5: begin ma = 25'(r_vol); mb = 25'(r_near); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign sq_sum = {1'b0, r_res} + {1'b0, r_bit};
    assign sq_ge  = {1'b0, r_rem} >= sq_sum;
    assign n_res  = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
    assign n_rem  = sq_ge ? r_rem - sq_sum[50:0] : r_rem;

    assign dv_t  = {r_r, r_q[38]};
    assign dv_ge = dv_t >= {1'b0, r_dv};
    assign n_r   = dv_ge ? 26'(dv_t - {1'b0, r_dv}) : dv_t[25:0];
    assign n_q   = {r_q[37:0], dv_ge};

    assign far_out = r_dsq > {5'd0, r_far2};
    assign near_in = r_dsq <= {5'd0, r_near2};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: if (i_start) n_state = i_spatial ? A_MUL : A_DONE;
            A_MUL:  if (r_step == 3'd6) n_state = A_CMP;
            A_CMP:  n_state = (far_out || near_in) ? A_DONE : A_SQRT;
            A_SQRT: if (r_bit[0]) n_state = A_DIV;
            A_DIV:  if (r_cnt == '0) n_state = A_DONE;
            A_DONE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        unique case (r_state)
            A_IDLE: begin
                r_step <= '0;
                r_vol  <= i_vol;
                r_near <= i_near;
                r_far  <= i_far;
                r_ax   <= dx[24] ? 25'(-dx) : 25'(dx);
                r_ay   <= dy[24] ? 25'(-dy) : 25'(dy);
                r_az   <= dz[24] ? 25'(-dz) : 25'(dz);
                r_aud  <= i_vol;
            end
            A_MUL: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1: r_dsq <= 51'(r_prod);
                    3'd2, 3'd3: r_dsq <= r_dsq + 51'(r_prod);
                    3'd4: r_far2 <= r_prod[45:0];
                    3'd5: r_near2 <= r_prod[45:0];
                    3'd6: r_vn <= r_prod[38:0];
                    default: ;
                endcase
            end
            A_CMP: begin
                r_aud <= far_out ? 16'd0 : r_vol;
                r_rem <= r_dsq;
                r_res <= '0;
                r_bit <= 51'd1 << 50;
            end
            A_SQRT: begin
                r_rem <= n_rem;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                r_q   <= r_vn;
                r_r   <= '0;
                r_cnt <= 6'd38;
                r_dv  <= (n_res == '0) ? 26'd1 : n_res[25:0];
            end
            A_DIV: begin
                r_q   <= n_q;
                r_r   <= n_r;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_aud <= n_q[15:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_state == A_DONE;
    assign o_aud  = r_aud;
endmodule

// File: hw/rtl/vsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_dp
// datapath: voice table, age ranks, best candidate, result and output beat
// ----------------------------------------------------------------------------
module vsa_dp
    import vsa_pkg::*;
#(
    parameter int VOICE_SLOTS = DEF_VOICE_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in        i_in,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out
);
    localparam int IW = $clog2(VOICE_SLOTS);
    localparam int CW = $clog2(VOICE_SLOTS + 1);

    t_in          r_req;
    logic [5:0]   r_max;
    logic [23:0]  r_lx, r_ly, r_lz;
    logic         r_valid [VOICE_SLOTS];
    logic [IW-1:0] r_age  [VOICE_SLOTS];
    logic [CW-1:0] r_count;
    logic [31:0]  r_next;
    logic [CW-1:0] r_idx;
    logic         r_bfound;
    logic [IW-1:0] r_bidx, r_bage;
    logic [7:0]   r_bpri;
    logic [15:0]  r_baud;
    logic [31:0]  r_bhandle;
    logic [15:0]  r_ia;
    t_status      r_rstatus;
    logic [31:0]  r_rnew, r_revh;
    logic         r_rev;
    logic         r_out_valid;
    t_out         r_out;

    logic [IW-1:0] idx_ix, fs_idx, ft_idx;
    logic          has_free, idx_end, better;
    logic [$bits(t_slot)-1:0] ram_rdata;
    t_slot         rd, wr;
    logic          aud_done;
    logic [15:0]   aud_res;

    assign idx_ix  = r_idx[IW-1:0];
    assign idx_end = r_idx == CW'(VOICE_SLOTS);
    assign rd      = t_slot'(ram_rdata);

    always_comb begin
        has_free = 1'b0;
        fs_idx   = '0;
        for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                has_free = 1'b1;
                fs_idx   = IW'(i);
            end
        end
    end

    assign ft_idx = i_cmd.free_best ? r_bidx : idx_ix;

    always_comb begin
        wr.handle  = i_cmd.alloc ? r_next : rd.handle;
        wr.prio    = r_req.priority_req;
        wr.volume  = r_req.volume;
        wr.spatial = r_req.spatialized;
        wr.pos_x   = r_req.pos_x;
        wr.pos_y   = r_req.pos_y;
        wr.pos_z   = r_req.pos_z;
        wr.near_d  = r_req.near_distance;
        wr.far_d   = r_req.far_distance;
    end

    vsa_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (VOICE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc | i_cmd.wr_params),
        .i_waddr (i_cmd.alloc ? fs_idx : idx_ix),
        .i_wdata (wr),
        .i_raddr (idx_ix),
        .o_rdata (ram_rdata)
    );

    vsa_aud u_aud (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.aud_start),
        .i_vol     (i_cmd.aud_sel_ram ? rd.volume : r_req.volume),
        .i_spatial (i_cmd.aud_sel_ram ? rd.spatial : r_req.spatialized),
        .i_x       (i_cmd.aud_sel_ram ? rd.pos_x : r_req.pos_x),
        .i_y       (i_cmd.aud_sel_ram ? rd.pos_y : r_req.pos_y),
        .i_z       (i_cmd.aud_sel_ram ? rd.pos_z : r_req.pos_z),
        .i_lx      (r_lx),
        .i_ly      (r_ly),
        .i_lz      (r_lz),
        .i_near    (i_cmd.aud_sel_ram ? rd.near_d : r_req.near_distance),
        .i_far     (i_cmd.aud_sel_ram ? rd.far_d : r_req.far_distance),
        .o_done    (aud_done),
        .o_aud     (aud_res)
    );

    assign better = !r_bfound || rd.prio < r_bpri ||
        (rd.prio == r_bpri && (aud_res < r_baud ||
        (aud_res == r_baud && r_age[idx_ix] < r_bage)));

    always_comb begin
        o_sts.op          = r_req.operation;
        o_sts.cap_hit     = (r_max != '0) && (32'(r_count) >= 32'(r_max));
        o_sts.aud_done    = aud_done;
        o_sts.idx_end     = idx_end;
        o_sts.idx_valid   = !idx_end && r_valid[idx_ix];
        o_sts.match       = rd.handle == r_req.handle;
        o_sts.handle_zero = r_req.handle == '0;
        o_sts.refuse      = !r_bfound || r_req.priority_req < r_bpri ||
            (r_req.priority_req == r_bpri && r_ia <= r_baud);
        o_sts.has_free    = has_free;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // table control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
            end
            r_count <= '0;
            r_next  <= 32'd1;
            r_max   <= MAX_VOICES_RST;
            r_lx    <= '0;
            r_ly    <= '0;
            r_lz    <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.load_req) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.free_best || i_cmd.free_idx) begin
                r_valid[ft_idx] <= 1'b0;
                for (int i = 0; i < VOICE_SLOTS; i++) begin
                    if (r_valid[i] && r_age[i] > r_age[ft_idx]) begin
                        r_age[i] <= r_age[i] - IW'(1);
                    end
                end
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.alloc) begin
                r_valid[fs_idx] <= 1'b1;
                r_age[fs_idx]   <= IW'(r_count);
                r_count         <= r_count + CW'(1);
                r_next          <= (r_next == 32'hFFFF_FFFF) ? 32'd1 : r_next + 32'd1;
            end
            if (i_cmd.set_listener) begin
                r_lx <= r_req.pos_x;
                r_ly <= r_req.pos_y;
                r_lz <= r_req.pos_z;
            end
        end
    end

    // request, best candidate and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req     <= i_in;
            r_bfound  <= 1'b0;
            r_rstatus <= ST_DONE;
            r_rnew    <= '0;
            r_rev     <= 1'b0;
            r_revh    <= '0;
        end
        if (i_cmd.save_ia) begin
            r_ia <= aud_res;
        end
        if (i_cmd.consider && better) begin
            r_bfound  <= 1'b1;
            r_bidx    <= idx_ix;
            r_bage    <= r_age[idx_ix];
            r_bpri    <= rd.prio;
            r_baud    <= aud_res;
            r_bhandle <= rd.handle;
        end
        if (i_cmd.st_we) begin
            r_rstatus <= i_cmd.st_code;
        end
        if (i_cmd.alloc) begin
            r_rnew <= r_next;
        end
        if (i_cmd.free_best) begin
            r_rev  <= 1'b1;
            r_revh <= r_bhandle;
        end
        if (i_cmd.out_load) begin
            r_out.status         <= r_rstatus;
            r_out.new_handle     <= r_rnew;
            r_out.evicted        <= r_rev;
            r_out.evicted_handle <= r_revh;
            r_out.active_count   <= 6'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

// File: hw/rtl/vsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_ctrl
// sequencer for play, update, stop and listener requests
// ----------------------------------------------------------------------------
module vsa_ctrl
    import vsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CAP;
                end
            end
            S_CAP: begin
                unique case (i_sts.op)
                    OP_PLAY:             n_state = i_sts.cap_hit ? S_INSC : S_ALLOC;
                    OP_UPDATE, OP_STOP:  n_state = S_FSCAN;
                    OP_LISTENER:         n_state = S_LIS;
                    default:             n_state = S_LIS;
                endcase
            end
            S_INSC:   if (i_sts.aud_done) n_state = S_SCAN;
            S_SCAN: begin
                if (i_sts.idx_end) begin
                    n_state = S_DECIDE;
                end else if (i_sts.idx_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:   n_state = S_SCORE;
            S_SCORE:  if (i_sts.aud_done) n_state = S_SCAN;
            S_DECIDE: n_state = i_sts.refuse ? S_DONE : S_ALLOC;
            S_ALLOC:  n_state = S_DONE;
            S_FSCAN: begin
                if (i_sts.idx_end || i_sts.handle_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.idx_valid) begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK:   n_state = i_sts.match ? S_DONE : S_FSCAN;
            S_LIS:    n_state = S_DONE;
            S_DONE:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.st_code = ST_DONE;
        unique case (r_state)
            S_IDLE: o_cmd.load_req = i_in_valid;
            S_CAP: begin
                if (i_sts.op == OP_PLAY && i_sts.cap_hit) begin
                    o_cmd.aud_start = 1'b1;
                end
            end
            S_INSC: o_cmd.save_ia = i_sts.aud_done;
            S_SCAN: begin
                if (!i_sts.idx_end && !i_sts.idx_valid) begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LOAD: begin
                o_cmd.aud_start   = 1'b1;
                o_cmd.aud_sel_ram = 1'b1;
            end
            S_SCORE: begin
                o_cmd.consider = i_sts.aud_done;
                o_cmd.idx_inc  = i_sts.aud_done;
            end
            S_DECIDE: begin
                if (i_sts.refuse) begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_REFUSED;
                end else begin
                    o_cmd.free_best = 1'b1;
                end
            end
            S_ALLOC: begin
                if (i_sts.has_free) begin
                    o_cmd.alloc = 1'b1;
                end else begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_NOSLOT;
                end
            end
            S_FSCAN: begin
                if (i_sts.idx_end || i_sts.handle_zero) begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = ST_UNKNOWN;
                end else if (!i_sts.idx_valid) begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_FCHK: begin
                if (i_sts.match) begin
                    o_cmd.wr_params = i_sts.op == OP_UPDATE;
                    o_cmd.free_idx  = i_sts.op == OP_STOP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_LIS:  o_cmd.set_listener = 1'b1;
            S_DONE: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule

// File: hw/rtl/voice_steal_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_steal_allocator
// Takes one request beat at a time and returns one result beat. An update or
// stop scans the slots for its handle; a play below the voice cap and a set
// listener do not scan. A play at the cap scores the request and every live
// voice in one shared audibility unit, which runs the square root and divide
// only for a spatial voice inside the attenuation band (26 square root steps
// and 39 divide steps). The result register frees the input while a result
// beat waits.
// ----------------------------------------------------------------------------
module voice_steal_allocator
    import vsa_pkg::*;
#(
    parameter int VOICE_SLOTS = DEF_VOICE_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    vsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vsa_dp #(
        .VOICE_SLOTS (VOICE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule

// File: bench/voice_steal_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_steal_allocator_tb
// Drives request beats from a queue through a valid/ready driver and checks
// every result beat against a cycle-free predictor of the voice table, the
// score comparison and the steal/refuse decision. Runs several voice caps,
// random stalls on both sides, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module voice_steal_allocator_tb;
    import vsa_pkg::*;

    localparam int  NSLOT      = 32;
    localparam int  CYCLE_CAP  = 8000000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in  req_beat;
    logic out_valid;
    logic out_ready;
    t_out res_beat;
    logic cfg_we;
    logic [5:0] cfg_data;

    voice_steal_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (req_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (res_beat),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // voice table mirror
    bit          v_live [NSLOT];
    logic [31:0] v_handle [NSLOT];
    logic [7:0]  v_prio [NSLOT];
    logic [15:0] v_vol [NSLOT];
    bit          v_spat [NSLOT];
    longint      v_x [NSLOT], v_y [NSLOT], v_z [NSLOT];
    longint      v_near [NSLOT], v_far [NSLOT];
    int          v_age [NSLOT];
    longint      lis_x, lis_y, lis_z;
    logic [31:0] handle_ctr;
    int          voice_cap;

    t_in  stim_q [$];
    t_out result_q [$];
    int   errors;
    int   send_idle, recv_idle;
    int   hold_cnt;
    bit   hold_kick, hold_seen;
    int   cycles;
    int   plays_made;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void add_stim(t_in it);
        stim_q = {stim_q, it};
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint loudness(logic [15:0] vol, bit sp, longint x, longint y,
                                        longint z, longint nq, longint fq);
        longint dx, dy, dz;
        longint unsigned dsq, d;
        dx = x - lis_x;
        dy = y - lis_y;
        dz = z - lis_z;
        if (!sp) return vol;
        dsq = dx * dx + dy * dy + dz * dz;
        if (dsq > fq * fq) return 0;
        if (dsq > nq * nq) begin
            d = root_floor(dsq);
            if (d == 0) d = 1;
            return (longint'(vol) * nq) / d;
        end
        return vol;
    endfunction

    function automatic int live_voices();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (v_live[i]) n++;
        return n;
    endfunction

    function automatic void release_voice(int s);
        v_live[s] = 0;
        for (int i = 0; i < NSLOT; i++)
            if (v_live[i] && v_age[i] > v_age[s]) v_age[i]--;
    endfunction

    function automatic void store_params(int s, t_in it);
        v_prio[s] = it.priority_req;
        v_vol[s]  = it.volume;
        v_spat[s] = it.spatialized;
        v_x[s]    = it.pos_x;
        v_y[s]    = it.pos_y;
        v_z[s]    = it.pos_z;
        v_near[s] = it.near_distance;
        v_far[s]  = it.far_distance;
    endfunction

    function automatic int lookup(logic [31:0] h);
        if (h == 0) return -1;
        for (int i = 0; i < NSLOT; i++)
            if (v_live[i] && v_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic t_out allocate(t_in it);
        t_out r;
        int s, w;
        bit ok;
        longint ia, wa, a;
        logic [7:0] wp;
        r = '0;
        r.status = ST_DONE;
        case (it.operation)
            OP_PLAY: begin
                ok = 1;
                if (voice_cap > 0 && live_voices() >= voice_cap) begin
                    ia = loudness(it.volume, it.spatialized, it.pos_x, it.pos_y, it.pos_z,
                                  it.near_distance, it.far_distance);
                    w = -1;
                    wp = 0;
                    wa = 0;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!v_live[i]) continue;
                        a = loudness(v_vol[i], v_spat[i], v_x[i], v_y[i], v_z[i],
                                     v_near[i], v_far[i]);
                        if (w < 0 || v_prio[i] < wp || (v_prio[i] == wp &&
                            (a < wa || (a == wa && v_age[i] < v_age[w])))) begin
                            w = i;
                            wp = v_prio[i];
                            wa = a;
                        end
                    end
                    if (w < 0 || it.priority_req < wp || (it.priority_req == wp && ia <= wa)) begin
                        r.status = ST_REFUSED;
                        ok = 0;
                    end else begin
                        r.evicted = 1;
                        r.evicted_handle = v_handle[w];
                        release_voice(w);
                    end
                end
                if (ok) begin
                    s = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (!v_live[i] && s < 0) s = i;
                    if (s < 0) begin
                        r.status = ST_NOSLOT;
                    end else begin
                        v_age[s] = live_voices();
                        v_live[s] = 1;
                        v_handle[s] = handle_ctr;
                        store_params(s, it);
                        r.new_handle = handle_ctr;
                        handle_ctr++;
                        if (handle_ctr == 0) handle_ctr = 1;
                    end
                end
            end
            OP_UPDATE: begin
                s = lookup(it.handle);
                if (s < 0) r.status = ST_UNKNOWN;
                else store_params(s, it);
            end
            OP_STOP: begin
                s = lookup(it.handle);
                if (s < 0) r.status = ST_UNKNOWN;
                else release_voice(s);
            end
            default: begin
                lis_x = it.pos_x;
                lis_y = it.pos_y;
                lis_z = it.pos_z;
            end
        endcase
        r.active_count = 6'(live_voices());
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 0;
        end else begin
            if (in_valid && in_ready) result_q = {result_q, allocate(req_beat)};
            if (!in_valid || in_ready) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    in_valid <= 1;
                    req_beat <= stim_q.pop_front();
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            out_ready <= 0;
            hold_cnt  <= 0;
            hold_seen <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t unexpected beat %p", $time, res_beat);
                    errors <= errors + 1;
                end else begin
                    e = result_q.pop_front();
                    if (e.status !== res_beat.status || e.new_handle !== res_beat.new_handle ||
                        e.evicted !== res_beat.evicted ||
                        e.evicted_handle !== res_beat.evicted_handle ||
                        e.active_count !== res_beat.active_count) begin
                        $display("%0t mismatch expected %p actual %p", $time, e, res_beat);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_kick != hold_seen) begin
                hold_seen <= hold_kick;
                hold_cnt  <= 400;
                out_ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                out_ready <= 0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    function automatic logic [31:0] pick_handle();
        int lo;
        case ($urandom_range(19))
            0: return 0;
            1: return $urandom;
            default: begin
                lo = (plays_made > 40) ? plays_made - 40 : 1;
                return $urandom_range(plays_made + 1, lo);
            end
        endcase
    endfunction

    function automatic t_in rand_item(t_op op);
        t_in it;
        it.operation    = op;
        it.handle       = pick_handle();
        it.priority_req = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        it.volume       = 16'($urandom);
        it.spatialized  = 1'($urandom_range(1));
        if ($urandom_range(9) == 0) begin
            it.pos_x = 24'($urandom);
            it.pos_y = 24'($urandom);
            it.pos_z = 24'($urandom);
            it.near_distance = 23'($urandom);
            it.far_distance  = 23'($urandom);
        end else begin
            it.pos_x = 24'($urandom_range(8191)) - 24'd4096;
            it.pos_y = 24'($urandom_range(8191)) - 24'd4096;
            it.pos_z = 24'($urandom_range(8191)) - 24'd4096;
            it.near_distance = 23'($urandom_range(3000));
            it.far_distance  = 23'($urandom_range(12000));
        end
        if (op == OP_PLAY) plays_made++;
        return it;
    endfunction

    function automatic t_op rand_op();
        int r;
        r = $urandom_range(99);
        if (r < 45) return OP_PLAY;
        if (r < 65) return OP_UPDATE;
        if (r < 90) return OP_STOP;
        return OP_LISTENER;
    endfunction

    task automatic drain();
        while (stim_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_cap(int v);
        @(posedge i_clk);
        cfg_we   <= 1;
        cfg_data <= 6'(v);
        voice_cap = v;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    initial begin
        int caps [8] = '{4, 1, 0, 8, 32, 2, 6, 3};
        t_in it;
        errors = 0;
        cycles = 0;
        plays_made = 0;
        hold_kick = 0;
        send_idle = 15;
        recv_idle = 83;
        in_valid = 0;
        req_beat = '0;
        cfg_we = 0;
        cfg_data = '0;
        i_rst_n = 0;
        for (int i = 0; i < NSLOT; i++) begin
            v_live[i] = 0;
            v_age[i]  = 0;
        end
        lis_x = 0;
        lis_y = 0;
        lis_z = 0;
        handle_ctr = 1;
        voice_cap = 32;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        set_cap(32);

        // directed: extremes and special cases
        it = '0;
        it.operation = OP_UPDATE;
        add_stim(it);
        it.operation = OP_STOP;
        it.handle = 32'hFFFF_FFFF;
        add_stim(it);
        it = '1;
        it.operation = OP_LISTENER;
        add_stim(it);
        it.operation = OP_PLAY;
        add_stim(it);
        it.pos_x = 24'sh800000;
        it.pos_y = 24'sh800000;
        it.pos_z = 24'sh800000;
        add_stim(it);
        it = '0;
        it.operation = OP_LISTENER;
        add_stim(it);
        it.operation = OP_PLAY;
        it.volume = 16'hFFFF;
        it.spatialized = 1;
        it.pos_x = 24'sd1000;
        it.near_distance = 23'd500;
        it.far_distance = 23'd800;
        add_stim(it);
        it.far_distance = 23'd5000;
        add_stim(it);
        it.near_distance = 23'd2000;
        add_stim(it);
        it.operation = OP_UPDATE;
        it.handle = 32'd3;
        it.priority_req = 8'hFF;
        add_stim(it);
        it.operation = OP_STOP;
        it.handle = 32'd1;
        add_stim(it);
        add_stim(it);
        plays_made = 5;
        drain();
        set_cap(2);
        for (int i = 0; i < 8; i++) add_stim(rand_item(OP_PLAY));
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle = 83;
                recv_idle = 15;
            end else if (p == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_cap(caps[p]);
            if (p == 6) hold_kick = ~hold_kick;
            for (int i = 0; i < 60; i++) begin
                add_stim(rand_item(rand_op()));
                if (i == 30 && p == 4) begin
                    drain();
                end
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
